### rtl/core/qes_pkg.sv
// ============================================================================
// qes_pkg
// Shared types, constants and helper functions for the quadrature encoder
// to MIDI system-exclusive block.
// ============================================================================
package qes_pkg;

    // Input sample and output byte as they travel on the ports.
    typedef struct packed {
        logic [1:0] enc_pins;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Configuration register file.
    typedef struct packed {
        logic [6:0] up_param;
        logic [6:0] down_param;
        logic [6:0] press_value;
        logic [6:0] release_value;
    } t_cfg;

    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_UP_PARAM      = 8'd0,
        CFG_DOWN_PARAM    = 8'd1,
        CFG_PRESS_VALUE   = 8'd2,
        CFG_RELEASE_VALUE = 8'd3
    } t_cfg_idx;

    localparam logic [6:0] UpParamRst      = 7'd9;
    localparam logic [6:0] DownParamRst    = 7'd8;
    localparam logic [6:0] PressValueRst   = 7'd127;
    localparam logic [6:0] ReleaseValueRst = 7'd0;

    // Command handed from the front end to the byte sequencer.
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       msg_valid;
        logic       down;
    } t_cmd;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // Phase tracker codes.
    localparam logic [1:0] IdleCode = 2'd3;

    // Next expected pin code for each phase, clockwise and counter-clockwise.
    function automatic logic [1:0] cw_next(input logic [1:0] phase);
        logic [1:0] r;
        unique case (phase)
            2'd0: r = 2'd2;
            2'd1: r = 2'd0;
            2'd2: r = 2'd3;
            2'd3: r = 2'd1;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ccw_next(input logic [1:0] phase);
        logic [1:0] r;
        unique case (phase)
            2'd0: r = 2'd1;
            2'd1: r = 2'd3;
            2'd2: r = 2'd0;
            2'd3: r = 2'd2;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    // System-exclusive message framing.
    localparam int unsigned MsgLen  = 11;
    localparam int unsigned PosW    = $clog2(MsgLen);
    localparam logic [PosW-1:0] LastPos = PosW'(MsgLen - 1);

    localparam logic [7:0] SysexStart = 8'hF0;
    localparam logic [7:0] SysexMfr   = 8'h43;
    localparam logic [7:0] SysexDev   = 8'h10;
    localparam logic [7:0] SysexModel = 8'h29;
    localparam logic [7:0] SysexCmd   = 8'h08;
    localparam logic [7:0] SysexZero  = 8'h00;
    localparam logic [7:0] SysexEnd   = 8'hF7;

    function automatic logic [7:0] sysex_byte(input logic [PosW-1:0] pos,
                                              input logic [6:0]      param,
                                              input logic [6:0]      value);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = SysexStart;
            4'd1:    b = SysexMfr;
            4'd2:    b = SysexDev;
            4'd3:    b = SysexModel;
            4'd4:    b = SysexCmd;
            4'd5:    b = SysexZero;
            4'd6:    b = SysexZero;
            4'd7:    b = {1'b0, param};
            4'd8:    b = SysexZero;
            4'd9:    b = {1'b0, value};
            4'd10:   b = SysexEnd;
            default: b = SysexEnd;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/quadrature_encoder_to_midi_sysex.sv
// ============================================================================
// quadrature_encoder_to_midi_sysex
// Quadrature encoder decoder that echoes received serial bytes and sends a
// pair of MIDI system-exclusive parameter messages on each detent.
// ============================================================================
// A sample is taken whenever the four-entry command queue has room;
// samples that produce no bytes never enter the queue. Each queued
// command is loaded into the sequencer and then delivers one byte per
// cycle unless the consumer stalls: the echo byte, if any, followed by
// 22 message bytes, so one item produces at most 23 bytes. The single
// byte output register holds the pending byte while the consumer stalls,
// and the sequencer waits until that byte is taken.
module quadrature_encoder_to_midi_sysex (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  qes_pkg::t_in_item               i_item,
    output logic                            empty,
    input  logic                            pop,
    output qes_pkg::t_out_item              o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qes_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [qes_pkg::CfgDataW-1:0]    i_cfg_data
);

    qes_pkg::t_cfg r_cfg;
    qes_pkg::t_cmd front_cmd;
    qes_pkg::t_cmd queue_cmd;
    logic          front_push;
    logic          queue_full;
    logic          queue_empty;
    logic          queue_pop;
    logic          out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_param      <= qes_pkg::UpParamRst;
            r_cfg.down_param    <= qes_pkg::DownParamRst;
            r_cfg.press_value   <= qes_pkg::PressValueRst;
            r_cfg.release_value <= qes_pkg::ReleaseValueRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qes_pkg::CFG_UP_PARAM:      r_cfg.up_param      <= i_cfg_data[6:0];
                qes_pkg::CFG_DOWN_PARAM:    r_cfg.down_param    <= i_cfg_data[6:0];
                qes_pkg::CFG_PRESS_VALUE:   r_cfg.press_value   <= i_cfg_data[6:0];
                qes_pkg::CFG_RELEASE_VALUE: r_cfg.release_value <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign full = queue_full;

    qes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push & ~queue_full),
        .i_item     (i_item),
        .o_cmd_push (front_push),
        .o_cmd      (front_cmd)
    );

    qes_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_data  (queue_cmd),
        .o_empty (queue_empty)
    );

    qes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_result    (o_result),
        .o_valid     (out_valid),
        .i_take      (pop)
    );

    assign empty = ~out_valid;

endmodule

### rtl/core/qes_front.sv
// ============================================================================
// qes_front
// Accepts encoder samples, runs the two phase trackers and turns each sample
// that has something to send into a command for the byte sequencer.
// ============================================================================
module qes_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  qes_pkg::t_in_item i_item,
    output logic              o_cmd_push,
    output qes_pkg::t_cmd     o_cmd
);

    logic [1:0] r_cw_phase;
    logic [1:0] r_ccw_phase;
    logic [1:0] n_cw_phase;
    logic [1:0] n_ccw_phase;
    logic       cw_hit;
    logic       ccw_hit;

    always_comb begin
        n_cw_phase = r_cw_phase;
        cw_hit     = 1'b0;
        if (i_item.enc_pins != r_cw_phase) begin
            if (i_item.enc_pins == qes_pkg::cw_next(r_cw_phase)) begin
                cw_hit     = (r_cw_phase == 2'd0);
                n_cw_phase = i_item.enc_pins;
            end else if (i_item.enc_pins == qes_pkg::IdleCode) begin
                n_cw_phase = i_item.enc_pins;
            end
        end
    end

    always_comb begin
        n_ccw_phase = r_ccw_phase;
        ccw_hit     = 1'b0;
        if (i_item.enc_pins != r_ccw_phase) begin
            if (i_item.enc_pins == qes_pkg::ccw_next(r_ccw_phase)) begin
                ccw_hit     = (r_ccw_phase == 2'd0);
                n_ccw_phase = i_item.enc_pins;
            end else if (i_item.enc_pins == qes_pkg::IdleCode) begin
                n_ccw_phase = i_item.enc_pins;
            end
        end
    end

    // Counter-clockwise wins when both trackers complete a detent together.
    always_comb begin
        o_cmd.echo_valid = i_item.rx_valid;
        o_cmd.echo_byte  = i_item.rx_byte;
        o_cmd.msg_valid  = cw_hit | ccw_hit;
        o_cmd.down       = ccw_hit;
    end

    assign o_cmd_push = i_accept & (i_item.rx_valid | cw_hit | ccw_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw_phase  <= qes_pkg::IdleCode;
            r_ccw_phase <= qes_pkg::IdleCode;
        end else if (i_accept) begin
            r_cw_phase  <= n_cw_phase;
            r_ccw_phase <= n_ccw_phase;
        end
    end

    // A detent completes only when leaving phase zero.
    a_cw_hit_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cw_hit |-> (r_cw_phase == 2'd0 && n_cw_phase == 2'd2))
        else $error("clockwise detent outside phase zero");

endmodule

### rtl/core/qes_fifo.sv
// ============================================================================
// qes_fifo
// Short command queue between the front end and the byte sequencer.
// ============================================================================
module qes_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qes_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output qes_pkg::t_cmd o_data,
    output logic          o_empty
);

    qes_pkg::t_cmd                 r_mem [qes_pkg::QDepth];
    logic [qes_pkg::QPtrW-1:0]     r_wr_ptr;
    logic [qes_pkg::QPtrW-1:0]     r_rd_ptr;
    logic [qes_pkg::QCntW-1:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    function automatic logic [qes_pkg::QCntW-1:0] QCntW_inc(input logic b);
        return {{(qes_pkg::QCntW-1){1'b0}}, b};
    endfunction

    assign o_full  = (r_count == qes_pkg::QCntW'(qes_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCntW_inc(do_push) - QCntW_inc(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= qes_pkg::QCntW'(qes_pkg::QDepth))
        else $error("command queue count beyond depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

endmodule

### rtl/core/qes_back.sv
// ============================================================================
// qes_back
// Byte sequencer: takes commands from the queue and streams the echo byte and
// the two system-exclusive messages through a one-entry output register.
// ============================================================================
module qes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qes_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_empty,
    input  qes_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output qes_pkg::t_out_item o_result,
    output logic               o_valid,
    input  logic               i_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_MSG1,
        S_MSG2
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [qes_pkg::PosW-1:0]   r_pos;
    logic [qes_pkg::PosW-1:0]   n_pos;
    qes_pkg::t_cmd              r_cmd;
    logic                       r_out_valid;
    logic                       n_out_valid;
    qes_pkg::t_out_item         r_out;
    qes_pkg::t_out_item         n_out;
    logic                       taken;
    logic                       adv;
    logic [6:0]                 param;
    logic                       pos_end;

    assign taken     = i_take & r_out_valid;
    assign adv       = (r_state != S_IDLE) & (~r_out_valid | taken);
    assign param     = r_cmd.down ? i_cfg.down_param : i_cfg.up_param;
    assign pos_end   = (r_pos == qes_pkg::LastPos);
    assign o_cmd_pop = (r_state == S_IDLE) & ~i_cmd_empty;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~taken;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = i_cmd.echo_valid ? S_ECHO : S_MSG1;
                    n_pos   = '0;
                end
            end
            S_ECHO: begin
                if (adv) begin
                    n_out.out_byte = r_cmd.echo_byte;
                    n_out.last     = ~r_cmd.msg_valid;
                    n_out_valid    = 1'b1;
                    n_state        = r_cmd.msg_valid ? S_MSG1 : S_IDLE;
                    n_pos          = '0;
                end
            end
            S_MSG1: begin
                if (adv) begin
                    n_out.out_byte = qes_pkg::sysex_byte(r_pos, param, i_cfg.press_value);
                    n_out.last     = 1'b0;
                    n_out_valid    = 1'b1;
                    n_pos          = pos_end ? '0 : r_pos + 1'b1;
                    n_state        = pos_end ? S_MSG2 : S_MSG1;
                end
            end
            S_MSG2: begin
                if (adv) begin
                    n_out.out_byte = qes_pkg::sysex_byte(r_pos, param,
                                                         i_cfg.release_value);
                    n_out.last     = pos_end;
                    n_out_valid    = 1'b1;
                    n_pos          = pos_end ? '0 : r_pos + 1'b1;
                    n_state        = pos_end ? S_IDLE : S_MSG2;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_out <= n_out;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

    // A waiting byte that is not taken must still be there next cycle.
    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_take) |=> (r_out_valid && $stable(r_out)))
        else $error("pending output byte lost");

    // The sequence ends in the idle state exactly when a last byte is made.
    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_out.last) |=> (r_state == S_IDLE))
        else $error("last byte produced without ending the command");

endmodule
